@@ rtl/core/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine: list geometry,
// command and status codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int GRP_SIZE = 8;
  localparam int GRP_BITS = $clog2(GRP_SIZE);
  localparam int NUM_GRP  = CAPACITY / GRP_SIZE;
  localparam int GRP_W    = $clog2(NUM_GRP);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_FIND = 2'd2,
    S_DONE = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

@@ rtl/core/olist_cell.sv @@
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds a word, takes it from either neighbour or from the
// command, and compares it against the search key.
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                           clk_i,
  input  olist_pkg::cell_ctrl_t          ctrl_i,
  input  logic [olist_pkg::DATA_W-1:0]   new_word_i,
  input  logic [olist_pkg::DATA_W-1:0]   left_word_i,
  input  logic [olist_pkg::DATA_W-1:0]   right_word_i,
  input  logic [olist_pkg::DATA_W-1:0]   key_i,
  input  logic                           live_i,
  output logic [olist_pkg::DATA_W-1:0]   word_o,
  output logic                           hit_o
);

  logic [olist_pkg::DATA_W-1:0] word_q;
  logic [olist_pkg::DATA_W-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load_new) begin
      word_d = new_word_i;
    end else if (ctrl_i.take_left) begin
      word_d = left_word_i;
    end else if (ctrl_i.take_right) begin
      word_d = right_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  // only occupied slots may match
  assign hit_o  = live_i && (word_q == key_i);

endmodule

@@ rtl/core/olist_chain.sv @@
// ----------------------------------------------------------------------------
// olist_chain
// Row of list cells. Decodes the command per slot, shifts the row on
// insert and delete, and gathers the match vector and the deleted word.
// ----------------------------------------------------------------------------
module olist_chain (
  input  logic                              clk_i,
  input  olist_pkg::op_e                    op_i,
  input  logic [olist_pkg::POS_W-1:0]       pos_i,
  input  logic [olist_pkg::CNT_W-1:0]       count_i,
  input  logic [olist_pkg::DATA_W-1:0]      word_i,
  output logic [olist_pkg::CAPACITY-1:0]    hit_o,
  output logic [olist_pkg::DATA_W-1:0]      taken_o
);

  logic [olist_pkg::DATA_W-1:0] words [olist_pkg::CAPACITY];

  for (genvar i = 0; i < olist_pkg::CAPACITY; i++) begin : g_cell
    olist_pkg::cell_ctrl_t        ctrl;
    logic [olist_pkg::DATA_W-1:0] left_word;
    logic [olist_pkg::DATA_W-1:0] right_word;
    logic                         at_pos;
    logic                         past_pos;
    logic                         live;

    assign at_pos   = (pos_i == olist_pkg::POS_W'(i));
    assign past_pos = (olist_pkg::POS_W'(i) > pos_i);
    assign live     = (olist_pkg::CNT_W'(i) < count_i);

    assign ctrl.load_new   = (op_i == olist_pkg::OP_INSERT) && at_pos;
    assign ctrl.take_left  = (op_i == olist_pkg::OP_INSERT) && past_pos;
    assign ctrl.take_right = (op_i == olist_pkg::OP_DELETE) && (at_pos || past_pos);

    if (i == 0) begin : g_head
      assign left_word = '0;
    end else begin : g_body
      assign left_word = words[i-1];
    end

    if (i == olist_pkg::CAPACITY - 1) begin : g_tail
      assign right_word = words[i];
    end else begin : g_mid
      assign right_word = words[i+1];
    end

    olist_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_word_i   (word_i),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .key_i        (word_i),
      .live_i       (live),
      .word_o       (words[i]),
      .hit_o        (hit_o[i])
    );
  end

  // one-hot pick of the slot at the command position
  always_comb begin
    taken_o = '0;
    for (int i = 0; i < olist_pkg::CAPACITY; i++) begin
      if (pos_i == olist_pkg::POS_W'(i)) begin
        taken_o = taken_o | words[i];
      end
    end
  end

endmodule

@@ rtl/core/ordered_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list of 64 signed 32-bit words held in a row of cells,
// with positional insert, positional delete and first-match search.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries a command in tuser (insert,
// delete or search) and a value and position in tdata; one response
// leaves on the master stream with a status, the deleted word, the index
// of the first match and the element count after the command. Requests
// are taken one at a time. Insert and delete move the whole row of cells
// by one slot in their execute step; a request passes through accept,
// execute and respond before the next request is taken. A search latches
// the match flags of all cells in the execute cycle and then scans them
// eight slots per cycle from the head, stopping at the group of eight
// that holds the first match or, on a miss, after all eight groups.
// The response register holds its result while the master side stalls;
// no new request is taken until it has gone. Slots are not cleared at
// reset: only occupied slots are ever read or compared.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], position[38:32], zero[39]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], removed_value[33:2],
                                     // found_index[39:34], count[46:40],
                                     // zero[47]
);

  olist_pkg::state_e state_q, state_d;

  // latched request
  logic [1:0]                        func_q;
  logic [olist_pkg::DATA_W-1:0]      value_q;
  logic [olist_pkg::POS_W-1:0]       pos_q;

  // list occupancy
  logic [olist_pkg::CNT_W-1:0]       count_q, count_d;

  // search scan
  logic [olist_pkg::CAPACITY-1:0]    hit_q, hit_d;
  logic [olist_pkg::GRP_W-1:0]       grp_q, grp_d;

  // response fields
  olist_pkg::status_e                status_q, status_d;
  logic [olist_pkg::DATA_W-1:0]      removed_q, removed_d;
  logic [olist_pkg::IDX_W-1:0]       found_q, found_d;

  olist_pkg::op_e                    op;
  logic [olist_pkg::CAPACITY-1:0]    hits;
  logic [olist_pkg::DATA_W-1:0]      taken;
  logic [olist_pkg::GRP_SIZE-1:0]    grp_hits;
  logic [olist_pkg::GRP_BITS-1:0]    grp_first;
  logic                              s_fire;
  logic                              m_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == olist_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == olist_pkg::S_DONE);
  assign m_axis_tdata  = {1'b0, count_q, found_q, removed_q, status_q};

  // --------------------------------------------------------------------------
  // Cell row: shifts only in the execute cycle of a legal insert or delete
  // --------------------------------------------------------------------------
  olist_chain u_chain (
    .clk_i   (clk_i),
    .op_i    (op),
    .pos_i   (pos_q),
    .count_i (count_q),
    .word_i  (value_q),
    .hit_o   (hits),
    .taken_o (taken)
  );

  // --------------------------------------------------------------------------
  // First match within the current group of eight, head first
  // --------------------------------------------------------------------------
  assign grp_hits = hit_q[grp_q * olist_pkg::GRP_SIZE +: olist_pkg::GRP_SIZE];

  always_comb begin
    grp_first = '0;
    for (int j = olist_pkg::GRP_SIZE - 1; j >= 0; j--) begin
      if (grp_hits[j]) begin
        grp_first = olist_pkg::GRP_BITS'(j);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    hit_d     = hit_q;
    grp_d     = grp_q;
    status_d  = status_q;
    removed_d = removed_q;
    found_d   = found_q;
    op        = olist_pkg::OP_HOLD;

    unique case (state_q)
      olist_pkg::S_IDLE: begin
        if (s_fire) begin
          state_d = olist_pkg::S_EXEC;
        end
      end

      olist_pkg::S_EXEC: begin
        status_d  = olist_pkg::ST_OK;
        removed_d = '0;
        found_d   = '0;
        state_d   = olist_pkg::S_DONE;
        unique case (func_q)
          olist_pkg::FUNC_INSERT: begin
            // range check takes precedence over the full check
            if (pos_q > olist_pkg::POS_W'(count_q)) begin
              status_d = olist_pkg::ST_RANGE;
            end else if (count_q == olist_pkg::CNT_W'(olist_pkg::CAPACITY)) begin
              status_d = olist_pkg::ST_FULL;
            end else begin
              op      = olist_pkg::OP_INSERT;
              count_d = count_q + 1'b1;
            end
          end
          olist_pkg::FUNC_DELETE: begin
            if (pos_q >= olist_pkg::POS_W'(count_q)) begin
              status_d = olist_pkg::ST_RANGE;
            end else begin
              op        = olist_pkg::OP_DELETE;
              removed_d = taken;
              count_d   = count_q - 1'b1;
            end
          end
          olist_pkg::FUNC_SEARCH: begin
            hit_d   = hits;
            grp_d   = '0;
            state_d = olist_pkg::S_FIND;
          end
          default: begin
            // unused command: report ok and leave the list alone
          end
        endcase
      end

      olist_pkg::S_FIND: begin
        if (|grp_hits) begin
          found_d = {grp_q, grp_first};
          state_d = olist_pkg::S_DONE;
        end else if (grp_q == olist_pkg::GRP_W'(olist_pkg::NUM_GRP - 1)) begin
          status_d = olist_pkg::ST_MISS;
          state_d  = olist_pkg::S_DONE;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end

      olist_pkg::S_DONE: begin
        if (m_fire) begin
          state_d = olist_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      func_q  <= s_axis_tuser;
      value_q <= s_axis_tdata[31:0];
      pos_q   <= s_axis_tdata[38:32];
    end
    hit_q     <= hit_d;
    grp_q     <= grp_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olist_pkg::CNT_W'(olist_pkg::CAPACITY))
    else $error("element count above capacity");

  a_req_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> state_q == olist_pkg::S_EXEC)
    else $error("accepted request not executed next cycle");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olist_pkg::S_EXEC && op == olist_pkg::OP_INSERT)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the list by one");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olist_pkg::S_EXEC && op == olist_pkg::OP_DELETE)
      |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not shrink the list by one");

  a_resp_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire |=> s_axis_tready && !m_axis_tvalid)
    else $error("engine not free after response taken");

endmodule
